// File: src/rgb565_to_mono_frame_packer_core_macros.svh
// Assertion helpers shared by the RTL.
`ifndef RGB565_TO_MONO_FRAME_PACKER_CORE_MACROS_SVH
`define RGB565_TO_MONO_FRAME_PACKER_CORE_MACROS_SVH

`ifndef SYNTH
`define R2MFP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define R2MFP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define R2MFP_ASSERT(label, clk, rst, prop, msg)
`define R2MFP_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// File: src/r2mfp_pkg.sv
package r2mfp_pkg;

   localparam int FRAME_WIDTH  = 400;
   localparam int FRAME_HEIGHT = 300;
   localparam int ROW_BYTES    = (FRAME_WIDTH + 7) / 8;
   localparam int STORE_BYTES  = ROW_BYTES * FRAME_HEIGHT;
   localparam int ADDR_W       = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

   localparam logic [15:0] THRESHOLD_RESET = 16'h8000;
   localparam logic [7:0]  FILL_BYTE       = 8'hFF;
   localparam logic [7:0]  LEFT_BIT_MASK   = 8'h80;

   // request function codes
   localparam logic [1:0] FUNC_WRITE    = 2'd0;
   localparam logic [1:0] FUNC_READ     = 2'd1;
   localparam logic [1:0] FUNC_FULL_REQ = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_READ    = 2'd0;
   localparam logic [1:0] KIND_FULL    = 2'd1;
   localparam logic [1:0] KIND_PARTIAL = 2'd2;

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_READ,
      OP_FULL_REQ,
      OP_NONE
   } op_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [8:0]  x_pos;
      logic [8:0]  y_pos;
      logic [15:0] pixel_color;
      logic        end_of_frame;
      logic [13:0] read_addr;
   } req_type;

   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] read_byte;
      logic [8:0] rect_left;
      logic [8:0] rect_top;
      logic [8:0] rect_right;
      logic [8:0] rect_bottom;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      op_type            op;
      logic              hit;    // pixel inside frame, or read address inside store
      logic [ADDR_W-1:0] addr;
      logic [7:0]        mask;
      logic              white;
      logic              eof;
      logic [8:0]        x;
      logic [8:0]        y;
   } item_type;

endpackage

// File: src/r2mfp_ram.sv
module r2mfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/r2mfp_front.sv
module r2mfp_front import r2mfp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   input  logic        csr_write_en,
   input  logic [15:0] csr_write_data,
   input  logic        q_full,
   input  logic        clearing,
   output logic        q_push,
   output item_type    q_item
);

   logic [15:0] threshold_ff, threshold_in;
   item_type    item;

   always_comb begin
      threshold_in = csr_write_en ? csr_write_data : threshold_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   always_comb begin
      item.op    = OP_NONE;
      item.hit   = 1'b0;
      item.addr  = '0;
      item.mask  = LEFT_BIT_MASK >> req_data.x_pos[2:0];
      item.white = (req_data.pixel_color >= threshold_ff);
      item.eof   = req_data.end_of_frame;
      item.x     = req_data.x_pos;
      item.y     = req_data.y_pos;
      unique case (req_data.func)
         FUNC_WRITE: begin
            item.op  = OP_WRITE;
            item.hit = (req_data.x_pos < FRAME_WIDTH) && (req_data.y_pos < FRAME_HEIGHT);
            if (item.hit) begin
               item.addr = ADDR_W'(req_data.y_pos) * ADDR_W'(ROW_BYTES)
                         + ADDR_W'(req_data.x_pos >> 3);
            end
         end
         FUNC_READ: begin
            item.op  = OP_READ;
            item.hit = (req_data.read_addr < STORE_BYTES);
            if (item.hit) begin
               item.addr = ADDR_W'(req_data.read_addr);
            end
         end
         FUNC_FULL_REQ: begin
            item.op = OP_FULL_REQ;
         end
         default: begin
            item.op = OP_NONE;
         end
      endcase
   end

   assign req_ready = !q_full && !clearing;
   assign q_push    = req_valid && req_ready;
   assign q_item    = item;

endmodule

// File: src/r2mfp_queue.sv
`include "rgb565_to_mono_frame_packer_core_macros.svh"

module r2mfp_queue import r2mfp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output item_type head_item
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = entry_ff[rd_ptr_ff];

   `R2MFP_ASSERT(a_q_count_bound, clock, reset, count_ff != 2'd3, "queue count out of range")
   `R2MFP_ASSERT(a_q_no_underflow, clock, reset, pop |-> count_ff != 2'd0, "pop from empty queue")
   `R2MFP_ASSERT(a_q_no_overflow, clock, reset, push |-> !full, "push into full queue")

endmodule

// File: src/r2mfp_back.sv
`include "rgb565_to_mono_frame_packer_core_macros.svh"

module r2mfp_back import r2mfp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_valid,
   input  item_type q_item,
   output logic     q_pop,
   output logic     clearing,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   // clear sweep
   logic              clear_ff, clear_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   // execute stage
   logic     s1_valid_ff, s1_valid_in;
   item_type s1_item_ff, s1_item_in;

   // last committed write, for read-after-write forwarding
   logic              lw_valid_ff, lw_valid_in;
   logic [ADDR_W-1:0] lw_addr_ff, lw_addr_in;
   logic [7:0]        lw_data_ff, lw_data_in;

   logic       full_pending_ff, full_pending_in;
   logic       dirty_valid_ff, dirty_valid_in;
   logic [8:0] dirty_left_ff, dirty_left_in;
   logic [8:0] dirty_top_ff, dirty_top_in;
   logic [8:0] dirty_right_ff, dirty_right_in;
   logic [8:0] dirty_bottom_ff, dirty_bottom_in;

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [7:0]        ram_wdata;
   logic [7:0]        ram_rdata;

   logic       advance;
   logic       fire;
   logic       pix_write;
   logic       emit;
   rsp_type    emit_data;
   logic [7:0] base_byte;
   logic [7:0] new_byte;
   logic       dv_px;
   logic [8:0] left_px, top_px, right_px, bottom_px;

   assign advance = !out_valid_ff || rsp_ready;
   assign fire    = advance && s1_valid_ff;
   assign q_pop   = advance && q_valid && !clear_ff;

   always_comb begin
      base_byte = (lw_valid_ff && (lw_addr_ff == s1_item_ff.addr)) ? lw_data_ff : ram_rdata;
      new_byte  = s1_item_ff.white ? (base_byte | s1_item_ff.mask)
                                   : (base_byte & ~s1_item_ff.mask);
      pix_write = (s1_item_ff.op == OP_WRITE) && s1_item_ff.hit;
   end

   // bounding box after this item's pixel
   always_comb begin
      dv_px     = dirty_valid_ff;
      left_px   = dirty_left_ff;
      top_px    = dirty_top_ff;
      right_px  = dirty_right_ff;
      bottom_px = dirty_bottom_ff;
      if (pix_write) begin
         dv_px = 1'b1;
         if (!dirty_valid_ff) begin
            left_px   = s1_item_ff.x;
            right_px  = s1_item_ff.x;
            top_px    = s1_item_ff.y;
            bottom_px = s1_item_ff.y;
         end else begin
            if (s1_item_ff.x < dirty_left_ff)   left_px   = s1_item_ff.x;
            if (s1_item_ff.x > dirty_right_ff)  right_px  = s1_item_ff.x;
            if (s1_item_ff.y < dirty_top_ff)    top_px    = s1_item_ff.y;
            if (s1_item_ff.y > dirty_bottom_ff) bottom_px = s1_item_ff.y;
         end
      end
   end

   always_comb begin
      emit            = 1'b0;
      emit_data       = '0;
      full_pending_in = full_pending_ff;
      dirty_valid_in  = dirty_valid_ff;
      dirty_left_in   = dirty_left_ff;
      dirty_top_in    = dirty_top_ff;
      dirty_right_in  = dirty_right_ff;
      dirty_bottom_in = dirty_bottom_ff;
      if (fire) begin
         unique case (s1_item_ff.op)
            OP_READ: begin
               emit               = 1'b1;
               emit_data.out_kind = KIND_READ;
               emit_data.read_byte = s1_item_ff.hit ? base_byte : 8'd0;
            end
            OP_FULL_REQ: begin
               full_pending_in = 1'b1;
            end
            OP_WRITE: begin
               dirty_valid_in  = dv_px;
               dirty_left_in   = left_px;
               dirty_top_in    = top_px;
               dirty_right_in  = right_px;
               dirty_bottom_in = bottom_px;
               if (s1_item_ff.eof) begin
                  if (full_pending_ff) begin
                     emit               = 1'b1;
                     emit_data.out_kind = KIND_FULL;
                     full_pending_in    = 1'b0;
                     dirty_valid_in     = 1'b0;
                  end else if (dv_px) begin
                     emit                  = 1'b1;
                     emit_data.out_kind    = KIND_PARTIAL;
                     emit_data.rect_left   = left_px;
                     emit_data.rect_top    = top_px;
                     emit_data.rect_right  = right_px;
                     emit_data.rect_bottom = bottom_px;
                     dirty_valid_in        = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in  = advance ? q_pop : s1_valid_ff;
      s1_item_in   = q_pop ? q_item : s1_item_ff;
      lw_valid_in  = advance ? (fire && pix_write) : lw_valid_ff;
      lw_addr_in   = (fire && pix_write) ? s1_item_ff.addr : lw_addr_ff;
      lw_data_in   = (fire && pix_write) ? new_byte : lw_data_ff;
      out_valid_in = (fire && emit) ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
      out_data_in  = (fire && emit) ? emit_data : out_data_ff;
      clr_addr_in  = clear_ff ? (clr_addr_ff + ADDR_W'(1)) : clr_addr_ff;
      clear_in     = clear_ff && (clr_addr_ff != ADDR_W'(STORE_BYTES - 1));
   end

   always_comb begin
      if (clear_ff) begin
         ram_we    = 1'b1;
         ram_waddr = clr_addr_ff;
         ram_wdata = FILL_BYTE;
      end else begin
         ram_we    = fire && pix_write;
         ram_waddr = s1_item_ff.addr;
         ram_wdata = new_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff        <= 1'b1;
         clr_addr_ff     <= '0;
         s1_valid_ff     <= 1'b0;
         lw_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         full_pending_ff <= 1'b1;
         dirty_valid_ff  <= 1'b0;
         dirty_left_ff   <= '0;
         dirty_top_ff    <= '0;
         dirty_right_ff  <= '0;
         dirty_bottom_ff <= '0;
      end else begin
         clear_ff        <= clear_in;
         clr_addr_ff     <= clr_addr_in;
         s1_valid_ff     <= s1_valid_in;
         lw_valid_ff     <= lw_valid_in;
         out_valid_ff    <= out_valid_in;
         full_pending_ff <= full_pending_in;
         dirty_valid_ff  <= dirty_valid_in;
         dirty_left_ff   <= dirty_left_in;
         dirty_top_ff    <= dirty_top_in;
         dirty_right_ff  <= dirty_right_in;
         dirty_bottom_ff <= dirty_bottom_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      lw_addr_ff  <= lw_addr_in;
      lw_data_ff  <= lw_data_in;
      out_data_ff <= out_data_in;
   end

   r2mfp_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (q_pop),
      .rd_addr (q_item.addr),
      .rd_data (ram_rdata)
   );

   assign clearing  = clear_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `R2MFP_ASSERT(a_no_pop_in_clear, clock, reset, clear_ff |-> !q_pop, "item taken during clear")
   `R2MFP_ASSERT(a_box_order, clock, reset, dirty_valid_ff |-> (dirty_left_ff <= dirty_right_ff && dirty_top_ff <= dirty_bottom_ff), "dirty box inverted")
   `R2MFP_ASSERT(a_box_in_frame, clock, reset, dirty_valid_ff |-> (dirty_right_ff < FRAME_WIDTH && dirty_bottom_ff < FRAME_HEIGHT), "dirty box outside frame")
   `R2MFP_ASSERT(a_full_clears_pending, clock, reset, (fire && emit && emit_data.out_kind == KIND_FULL) |=> (!full_pending_ff && !dirty_valid_ff), "full refresh left state pending")

endmodule

// File: src/rgb565_to_mono_frame_packer_core.sv
// RGB565 to 1bpp frame packer. Pixels are thresholded against csr_write_data
// (white at or above) and merged into a byte-wide frame store, MSB leftmost;
// the dirty box is tracked and an end-of-frame pixel yields a full or partial
// refresh transfer. Throughput is one request per cycle unless a result waits
// on rsp_ready: the frame store is a single RAM with one read and one write
// port, and the read-modify-write of consecutive pixels in the same byte is
// covered by forwarding the last write. A request is registered in the queue,
// the execute stage and the output register. After reset the store is swept
// to all white, one byte per cycle (15000 bytes, ROW_BYTES * FRAME_HEIGHT);
// req_ready stays low meanwhile, while threshold writes are taken at any time.
module rgb565_to_mono_frame_packer_core import r2mfp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_write_en,
   input  logic [15:0] csr_write_data
);

   logic     q_push;
   item_type q_push_item;
   logic     q_full;
   logic     q_pop;
   logic     q_head_valid;
   item_type q_head_item;
   logic     clearing;

   r2mfp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .q_full         (q_full),
      .clearing       (clearing),
      .q_push         (q_push),
      .q_item         (q_push_item)
   );

   r2mfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_push_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_item  (q_head_item)
   );

   r2mfp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_head_valid),
      .q_item    (q_head_item),
      .q_pop     (q_pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: bench/tb_rgb565_to_mono_frame_packer_core.sv
module tb_rgb565_to_mono_frame_packer_core import r2mfp_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_PRINTED = 40;

   // Mirror of the frame store, dirty box and refresh state.
   class refresh_scoreboard;
      logic [7:0]  mono_bytes [STORE_BYTES];
      logic [15:0] threshold;
      bit          box_valid;
      bit          full_due;
      logic [8:0]  box_left, box_top, box_right, box_bottom;
      rsp_type     expected_q[$];
      int          error_count;

      function new();
         foreach (mono_bytes[i]) mono_bytes[i] = FILL_BYTE;
         threshold = THRESHOLD_RESET;
         box_valid = 1'b0;
         full_due = 1'b1;
         box_left = '0;
         box_top = '0;
         box_right = '0;
         box_bottom = '0;
         error_count = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_request(req_type item);
         rsp_type want;
         int      idx;
         want = '0;
         case (item.func)
            FUNC_READ: begin
               want.out_kind = KIND_READ;
               if (int'(item.read_addr) < STORE_BYTES)
                  want.read_byte = mono_bytes[item.read_addr];
               expected_q.push_back(want);
            end
            FUNC_FULL_REQ: begin
               full_due = 1'b1;
            end
            FUNC_WRITE: begin
               if (int'(item.x_pos) < FRAME_WIDTH && int'(item.y_pos) < FRAME_HEIGHT) begin
                  idx = int'(item.y_pos) * ROW_BYTES + int'(item.x_pos >> 3);
                  mono_bytes[idx][7 - item.x_pos[2:0]] = (item.pixel_color >= threshold);
                  if (!box_valid) begin
                     box_left = item.x_pos;
                     box_right = item.x_pos;
                     box_top = item.y_pos;
                     box_bottom = item.y_pos;
                     box_valid = 1'b1;
                  end else begin
                     if (item.x_pos < box_left) box_left = item.x_pos;
                     if (item.x_pos > box_right) box_right = item.x_pos;
                     if (item.y_pos < box_top) box_top = item.y_pos;
                     if (item.y_pos > box_bottom) box_bottom = item.y_pos;
                  end
               end
               if (item.end_of_frame) begin
                  if (full_due) begin
                     full_due = 1'b0;
                     box_valid = 1'b0;
                     want.out_kind = KIND_FULL;
                     expected_q.push_back(want);
                  end else if (box_valid) begin
                     box_valid = 1'b0;
                     want.out_kind = KIND_PARTIAL;
                     want.rect_left = box_left;
                     want.rect_top = box_top;
                     want.rect_right = box_right;
                     want.rect_bottom = box_bottom;
                     expected_q.push_back(want);
                  end
               end
            end
            default: ;
         endcase
      endfunction

      task report(string msg);
         if (error_count < MAX_PRINTED) $display("MISMATCH @%0t: %s", $realtime, msg);
         error_count++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result with none expected, kind %0d", got.out_kind));
            return;
         end
         want = expected_q.pop_front();
         if (got.out_kind !== want.out_kind || got.read_byte !== want.read_byte ||
             got.rect_left !== want.rect_left || got.rect_top !== want.rect_top ||
             got.rect_right !== want.rect_right || got.rect_bottom !== want.rect_bottom)
            report($sformatf("got kind %0d byte %02h box %0d,%0d,%0d,%0d exp kind %0d byte %02h box %0d,%0d,%0d,%0d",
                             got.out_kind, got.read_byte, got.rect_left, got.rect_top,
                             got.rect_right, got.rect_bottom, want.out_kind, want.read_byte,
                             want.rect_left, want.rect_top, want.rect_right, want.rect_bottom));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_en = 1'b0;
   logic [15:0] csr_write_data = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   refresh_scoreboard board = new();

   rgb565_to_mono_frame_packer_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #5 clock = ~clock;

   // result side: check every transfer, then pick next cycle's ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_data);
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic req_type rand_item();
      logic [63:0] raw;
      raw = {$urandom(), $urandom()};
      return raw[$bits(req_type)-1:0];
   endfunction

   function automatic req_type pixel_item(int x, int y, logic [15:0] color, bit eof);
      req_type item;
      item = rand_item();
      item.func = FUNC_WRITE;
      item.x_pos = 9'(x);
      item.y_pos = 9'(y);
      item.pixel_color = color;
      item.end_of_frame = eof;
      return item;
   endfunction

   function automatic req_type read_item(int addr);
      req_type item;
      item = rand_item();
      item.func = FUNC_READ;
      item.read_addr = 14'(addr);
      return item;
   endfunction

   function automatic req_type full_req_item();
      req_type item;
      item = rand_item();
      item.func = FUNC_FULL_REQ;
      return item;
   endfunction

   function automatic req_type outside_pixel(bit eof);
      req_type item;
      if ($urandom_range(1))
         item = pixel_item($urandom_range(511, FRAME_WIDTH), $urandom_range(511),
                           16'($urandom()), eof);
      else
         item = pixel_item($urandom_range(511), $urandom_range(511, FRAME_HEIGHT),
                           16'($urandom()), eof);
      return item;
   endfunction

   // half the colors land right around the threshold
   function automatic logic [15:0] pick_color();
      logic [15:0] c;
      if ($urandom_range(1)) c = 16'($urandom());
      else c = board.threshold + 16'($urandom_range(2)) - 16'd1;
      return c;
   endfunction

   task automatic send_item(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      board.note_request(item);
   endtask

   // stop sending, let every expected result drain, then cover items with no result
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [15:0] value);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      board.threshold = value;
      @(posedge clock);
   endtask

   task automatic run_phase(input int n_items, input int send_pct, input int recv_pct);
      int      sent;
      int      pause_at;
      bit      paused;
      int      x0, y0, x1, y1, x, y;
      int      frame_len;
      int      roll;
      req_type item;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      paused = 1'b0;
      pause_at = $urandom_range(3 * n_items / 4, n_items / 4);
      while (sent < n_items) begin
         if ($urandom_range(9) == 0) begin
            x0 = 0;
            y0 = 0;
            x1 = FRAME_WIDTH - 1;
            y1 = FRAME_HEIGHT - 1;
         end else begin
            x0 = $urandom_range(FRAME_WIDTH - 1);
            y0 = $urandom_range(FRAME_HEIGHT - 1);
            x1 = x0 + $urandom_range(23);
            y1 = y0 + $urandom_range(7);
            if (x1 > FRAME_WIDTH - 1) x1 = FRAME_WIDTH - 1;
            if (y1 > FRAME_HEIGHT - 1) y1 = FRAME_HEIGHT - 1;
         end
         frame_len = $urandom_range(12, 1);
         for (int k = 0; k < frame_len; k++) begin
            x = $urandom_range(x1, x0);
            y = $urandom_range(y1, y0);
            roll = $urandom_range(99);
            if (k == frame_len - 1) begin
               // frame end; now and then on a pixel that falls outside
               if (roll < 10) item = outside_pixel(1'b1);
               else item = pixel_item(x, y, pick_color(), 1'b1);
            end else if (roll < 14) item = read_item(y * ROW_BYTES + x / 8);
            else if (roll < 18) item = read_item($urandom_range(16383));
            else if (roll < 21) item = full_req_item();
            else if (roll < 24) begin
               item = rand_item();
               item.func = FUNC_UNUSED;
            end else if (roll < 29) item = outside_pixel(1'b0);
            else item = pixel_item(x, y, pick_color(), 1'b0);
            send_item(item);
            if (item.func != FUNC_UNUSED) sent++;
            if (!paused && sent >= pause_at) begin
               paused = 1'b1;
               wait_idle();
            end
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed, reset threshold
      send_idle_pct = 0;
      recv_idle_pct = 30;
      send_item(read_item(0));
      send_item(pixel_item(0, 0, 16'h7FFF, 1'b0));
      send_item(pixel_item(FRAME_WIDTH - 1, FRAME_HEIGHT - 1, 16'h8000, 1'b0));
      send_item(pixel_item(7, 0, 16'h0000, 1'b0));
      send_item(read_item(0));
      send_item(read_item(STORE_BYTES - 1));
      send_item(read_item(STORE_BYTES));
      send_item(read_item(16383));
      send_item(pixel_item(FRAME_WIDTH, 5, 16'h0000, 1'b0));
      send_item(pixel_item(511, 511, 16'h0000, 1'b0));
      send_item(pixel_item(10, FRAME_HEIGHT, 16'h0000, 1'b0));
      send_item(pixel_item(0, 0, 16'hFFFF, 1'b1));       // first refresh is full
      send_item(pixel_item(450, 0, 16'h0000, 1'b1));     // nothing dirty: no result
      send_item(pixel_item(100, 50, 16'h0000, 1'b0));
      send_item(pixel_item(20, 200, 16'h0000, 1'b1));
      send_item(full_req_item());
      send_item(pixel_item(5, 5, 16'h1234, 1'b1));
      send_item(pixel_item(FRAME_WIDTH - 2, 1, 16'h0000, 1'b0));
      send_item(outside_pixel(1'b1));                    // eof on an ignored pixel still acts
      send_item(read_item(ROW_BYTES + ROW_BYTES - 1));
      begin
         req_type odd;
         odd = rand_item();
         odd.func = FUNC_UNUSED;
         send_item(odd);
      end
      wait_idle();
      write_threshold(16'hFFFF);
      send_item(pixel_item(1, 0, 16'hFFFE, 1'b0));
      send_item(pixel_item(2, 0, 16'hFFFF, 1'b1));
      send_item(read_item(0));
      wait_idle();
      write_threshold(16'h0000);
      send_item(pixel_item(3, 0, 16'h0000, 1'b1));
      send_item(read_item(0));
      wait_idle();

      write_threshold(16'($urandom()));
      run_phase(280, 16, 59);
      wait_idle();
      write_threshold(THRESHOLD_RESET);
      run_phase(280, 59, 16);
      wait_idle();
      write_threshold(16'($urandom()));
      run_phase(280, 0, 0);

      wait_idle();
      if (board.error_count == 0 && board.pending() == 0) begin
         $display("tb_rgb565_to_mono_frame_packer_core: done, clean");
      end else begin
         $display("tb_rgb565_to_mono_frame_packer_core: done, errors");
      end
      $finish;
   end

   // store sweep after reset plus ~850 items under heavy stalls fits well inside this
   initial begin
      #2ms;
      $display("tb_rgb565_to_mono_frame_packer_core: done, errors");
      $finish;
   end

endmodule
